FILE: rtl/core/sdip_pkg.sv
`default_nettype none

package sdip_pkg;

	// Parse phases: leading whitespace, digits (after a sign or the first digit), trailing.
	typedef enum logic [1:0] {
		PH_LEAD   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_TRAIL  = 2'd2
	} phase_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

endpackage

`default_nettype wire

FILE: rtl/core/strict_decimal_int32_parser_core.sv
`default_nettype none

// Channel  Direction  tdata fields (lowest bit first)              Meaning
// s_*      in         char_code[7:0]                              one string byte, zero ends it
// m_*      out        value[VALUE_BITS-1:0], parse_error, zeros   one result per terminator
//
// Cycles: one input beat can be taken in every clock cycle unless a terminator waits in
// the input stage (see Stalls). A byte is captured in the input stage, and the parse
// state is updated from it as it leaves; a terminator also loads the result register.
// Reset: arst_n clears the parse state and both valid flags at once.
// Stalls: only a terminator waits in the input stage, and only while the result register
// still holds a result that has not been taken; every other byte passes regardless.

module strict_decimal_int32_parser_core #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_tvalid,
	output logic                                         s_tready,
	input  wire logic [7:0]                              s_tdata,  // char_code[7:0]
	output logic                                         m_tvalid,
	input  wire logic                                    m_tready,
	// value[VALUE_BITS-1:0], parse_error[VALUE_BITS], then zero fill to whole bytes
	output logic [((VALUE_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int OUT_W = ((VALUE_BITS + 1 + 7) / 8) * 8;
	localparam int WIDE_W = VALUE_BITS + 4;

	// Largest magnitude of a negative result, and of a positive one.
	localparam logic [VALUE_BITS-1:0] NEG_LIMIT = {1'b1, {(VALUE_BITS - 1){1'b0}}};
	localparam logic [VALUE_BITS-1:0] POS_LIMIT = {1'b0, {(VALUE_BITS - 1){1'b1}}};

	// Input stage.
	logic       valid_s1;
	logic [7:0] char_s1;

	// Parse state.
	sdip_pkg::phase_t        phase_q, phase_d;
	logic                    neg_q, neg_d;
	logic                    seen_q, seen_d;
	logic [VALUE_BITS-1:0]   mag_q, mag_d;
	logic                    ovf_q, ovf_d;

	// Result register.
	logic                    res_valid_q;
	logic [VALUE_BITS-1:0]   res_value_q;
	logic                    res_err_q;

	logic                    is_term;
	logic                    is_blank;
	logic                    is_digit;
	logic                    is_sign;
	logic                    s1_fire;
	logic                    res_load;
	logic [WIDE_W-1:0]       mag_next;
	logic                    digit_ovf;
	logic                    out_of_range;
	logic [VALUE_BITS-1:0]   res_value_d;
	logic                    res_err_d;

	// Byte classes.
	always_comb begin
		is_term  = (char_s1 == sdip_pkg::CH_NUL);
		is_blank = char_s1 inside {sdip_pkg::CH_TAB, sdip_pkg::CH_LF, sdip_pkg::CH_VT,
			sdip_pkg::CH_FF, sdip_pkg::CH_CR, sdip_pkg::CH_SPACE};
		is_digit = char_s1 inside {[sdip_pkg::CH_0:sdip_pkg::CH_9]};
		is_sign  = (char_s1 == sdip_pkg::CH_MINUS) || (char_s1 == sdip_pkg::CH_PLUS);
	end

	// A terminator needs a free result register; every other byte moves on at once.
	assign s1_fire  = valid_s1 && (!is_term || !res_valid_q || m_tready);
	assign res_load = s1_fire && is_term;
	assign s_tready = !valid_s1 || s1_fire;

	// magnitude * 10 + digit, as two shifted copies and the digit; the low nibble of an
	// ASCII digit is its value.
	assign mag_next = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0}
		+ {{(WIDE_W - 4){1'b0}}, char_s1[3:0]};
	assign digit_ovf = (mag_next > {4'b0000, NEG_LIMIT});

	// Next parse state.
	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		seen_d  = seen_q;
		mag_d   = mag_q;
		ovf_d   = ovf_q;
		if (is_term) begin
			phase_d = sdip_pkg::PH_LEAD;
			neg_d   = 1'b0;
			seen_d  = 1'b0;
			mag_d   = '0;
			ovf_d   = 1'b0;
		end else begin
			case (phase_q)
				sdip_pkg::PH_LEAD: begin
					if (is_blank) begin
						phase_d = sdip_pkg::PH_LEAD;
					end else if (is_sign) begin
						neg_d   = (char_s1 == sdip_pkg::CH_MINUS);
						phase_d = sdip_pkg::PH_DIGITS;
					end else if (is_digit) begin
						phase_d = sdip_pkg::PH_DIGITS;
					end else begin
						phase_d = sdip_pkg::PH_TRAIL;
					end
				end
				sdip_pkg::PH_DIGITS: begin
					if (!is_digit) begin
						phase_d = sdip_pkg::PH_TRAIL;
					end
				end
				default: begin
					phase_d = sdip_pkg::PH_TRAIL;
				end
			endcase
			// Digits are taken only in the lead and digit phases.
			if (is_digit && phase_q != sdip_pkg::PH_TRAIL) begin
				seen_d = 1'b1;
				if (!ovf_q) begin
					if (digit_ovf) begin
						ovf_d = 1'b1;
						mag_d = NEG_LIMIT;
					end else begin
						mag_d = mag_next[VALUE_BITS-1:0];
					end
				end
			end
		end
	end

	// Result for a terminator, taken from the state before it.
	always_comb begin
		out_of_range = ovf_q || (neg_q ? (mag_q > NEG_LIMIT) : (mag_q > POS_LIMIT));
		res_err_d    = (phase_q == sdip_pkg::PH_TRAIL) || !seen_q || out_of_range;
		if (out_of_range) begin
			res_value_d = '0;
		end else if (neg_q) begin
			res_value_d = '0 - mag_q;
		end else begin
			res_value_d = mag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdip_pkg::PH_LEAD;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			mag_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (s1_fire) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			seen_q  <= seen_d;
			mag_q   <= mag_d;
			ovf_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_value_q <= res_value_d;
			res_err_q   <= res_err_d;
		end
	end

	assign m_tvalid = res_valid_q;

	always_comb begin
		m_tdata                     = {OUT_W{1'b0}};
		m_tdata[VALUE_BITS-1:0]     = res_value_q;
		m_tdata[VALUE_BITS]         = res_err_q;
	end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int VALUE_W = 32;
	localparam int RES_W = ((VALUE_W + 1 + 7) / 8) * 8;
	localparam logic [31:0] MAG_POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [31:0] MAG_NEG_LIMIT = 32'h8000_0000;
	localparam int PRESSURE_HOLD = 300;
	localparam int BYTES_PER_PHASE = 105;
	localparam int N_DIRECTED = 21;

	// One parse result as it leaves the block.
	typedef struct packed {
		logic        parse_error;
		logic [31:0] value;
	} parse_result_t;

	// Directed row: string body (terminator added by the walker) and, where it
	// is obvious, the result typed in by hand.
	typedef struct {
		string       text;
		bit          typed;
		logic [31:0] value;
		logic        err;
	} directed_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [RES_W-1:0] m_tdata;

	parse_result_t pending_parses[$];
	int error_count = 0;
	int bytes_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;

	// Shadow copy of the parse state.
	sdip_pkg::phase_t acc_phase;
	logic             acc_negative;
	logic             acc_seen;
	logic [31:0]      acc_mag;
	logic             acc_sticky_ovf;

	logic [7:0] blank_chars [6] = '{sdip_pkg::CH_TAB, sdip_pkg::CH_LF, sdip_pkg::CH_VT,
		sdip_pkg::CH_FF, sdip_pkg::CH_CR, sdip_pkg::CH_SPACE};

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{"",                     1, 32'h0000_0000, 1'b1},
		'{"0",                    1, 32'h0000_0000, 1'b0},
		'{"2147483647",           1, 32'h7FFF_FFFF, 1'b0},
		'{"-2147483648",          1, 32'h8000_0000, 1'b0},
		'{"2147483648",           1, 32'h0000_0000, 1'b1},
		'{"-2147483649",          1, 32'h0000_0000, 1'b1},
		'{"99999999999999999999", 1, 32'h0000_0000, 1'b1},
		'{"\011\012\013\014\015 +42", 0, 32'h0, 1'b0},
		'{"-",                    1, 32'h0000_0000, 1'b1},
		'{"+",                    1, 32'h0000_0000, 1'b1},
		'{"   ",                  1, 32'h0000_0000, 1'b1},
		'{"12abc",                0, 32'h0, 1'b0},
		'{"+-5",                  0, 32'h0, 1'b0},
		'{"7-",                   0, 32'h0, 1'b0},
		'{"\377",                 0, 32'h0, 1'b0},
		'{"5\200",                0, 32'h0, 1'b0},
		'{"12 ",                  0, 32'h0, 1'b0},
		'{"x12",                  0, 32'h0, 1'b0},
		'{"-0",                   0, 32'h0, 1'b0},
		'{"00000000002147483647", 0, 32'h0, 1'b0},
		'{"- 5/:",                0, 32'h0, 1'b0}
	};

	strict_decimal_int32_parser_core #(
		.VALUE_BITS(VALUE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic void clear_parse();
		acc_phase = sdip_pkg::PH_LEAD;
		acc_negative = 1'b0;
		acc_seen = 1'b0;
		acc_mag = 32'd0;
		acc_sticky_ovf = 1'b0;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == sdip_pkg::CH_TAB || c == sdip_pkg::CH_LF || c == sdip_pkg::CH_VT ||
			c == sdip_pkg::CH_FF || c == sdip_pkg::CH_CR || c == sdip_pkg::CH_SPACE;
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= sdip_pkg::CH_0 && c <= sdip_pkg::CH_9;
	endfunction

	// The magnitude never passes 2^31: once the next digit would push it
	// beyond, it is pinned there and the sticky overflow bit is set.
	function automatic void accumulate_digit(input logic [7:0] c);
		logic [31:0] d;
		d = {24'd0, c - sdip_pkg::CH_0};
		acc_seen = 1'b1;
		if (!acc_sticky_ovf) begin
			if (acc_mag > (MAG_NEG_LIMIT - d) / 32'd10) begin
				acc_sticky_ovf = 1'b1;
				acc_mag = MAG_NEG_LIMIT;
			end else begin
				acc_mag = acc_mag * 32'd10 + d;
			end
		end
	endfunction

	// Advances the shadow state by one byte; a terminator yields a result.
	function automatic void parse_char(input logic [7:0] c, output bit emits,
			output parse_result_t res);
		logic out_of_range;
		emits = 1'b0;
		res = '0;
		if (c == sdip_pkg::CH_NUL) begin
			emits = 1'b1;
			res.parse_error = (acc_phase == sdip_pkg::PH_TRAIL) || !acc_seen;
			out_of_range = acc_sticky_ovf ||
				(acc_negative ? (acc_mag > MAG_NEG_LIMIT) : (acc_mag > MAG_POS_LIMIT));
			if (out_of_range) begin
				res.parse_error = 1'b1;
				res.value = 32'd0;
			end else if (acc_negative) begin
				res.value = 32'd0 - acc_mag;
			end else begin
				res.value = acc_mag;
			end
			clear_parse();
		end else begin
			case (acc_phase)
				sdip_pkg::PH_LEAD: begin
					if (is_blank(c)) begin
						acc_phase = sdip_pkg::PH_LEAD;
					end else if (c == sdip_pkg::CH_MINUS || c == sdip_pkg::CH_PLUS) begin
						acc_negative = (c == sdip_pkg::CH_MINUS);
						acc_phase = sdip_pkg::PH_DIGITS;
					end else if (is_digit(c)) begin
						accumulate_digit(c);
						acc_phase = sdip_pkg::PH_DIGITS;
					end else begin
						acc_phase = sdip_pkg::PH_TRAIL;
					end
				end
				sdip_pkg::PH_DIGITS: begin
					if (is_digit(c))
						accumulate_digit(c);
					else
						acc_phase = sdip_pkg::PH_TRAIL;
				end
				default: acc_phase = sdip_pkg::PH_TRAIL;
			endcase
		end
	endfunction

	// Offers one byte, with random idle cycles ahead of it, and updates the
	// shadow state on the accepting edge.
	task automatic send_byte(input logic [7:0] c, input bit typed, input parse_result_t typed_res);
		bit emits;
		parse_result_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		parse_char(c, emits, res);
		if (emits)
			pending_parses.push_back(typed ? typed_res : res);
	endtask

	task automatic send_text(input logic [7:0] chars[$], input bit typed,
			input parse_result_t typed_res);
		foreach (chars[i])
			send_byte(chars[i], 1'b0, typed_res);
		send_byte(sdip_pkg::CH_NUL, typed, typed_res);
	endtask

	// Mostly well-formed numbers with random padding, sign and size, biased
	// toward the range limits, some with trailing junk; the rest is raw noise.
	task automatic send_random_string();
		logic [7:0] chars[$];
		string digits;
		longint num;
		int pick;
		parse_result_t none;
		none = '0;
		digits = "";
		pick = $urandom_range(99);
		if (pick < 12) begin
			repeat ($urandom_range(1, 6))
				chars.push_back(8'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(0, 2))
				chars.push_back(blank_chars[$urandom_range(5)]);
			case ($urandom_range(2))
				1: chars.push_back(sdip_pkg::CH_PLUS);
				2: chars.push_back(sdip_pkg::CH_MINUS);
				default: ;
			endcase
			pick = $urandom_range(99);
			if (pick < 35) begin
				digits = $sformatf("%0d", $urandom_range(0, 999));
			end else if (pick < 55) begin
				num = 64'd2147483645 + $urandom_range(0, 6);
				digits = $sformatf("%0d", num);
			end else if (pick < 75) begin
				num = {32'd0, $urandom()};
				digits = $sformatf("%0d", num);
			end else if (pick < 85) begin
				repeat ($urandom_range(11, 20))
					digits = {digits, $sformatf("%0d", $urandom_range(9))};
			end else if (pick < 93) begin
				digits = {"000", $sformatf("%0d", $urandom_range(0, 99))};
			end
			for (int i = 0; i < digits.len(); i++)
				chars.push_back(digits[i]);
			if ($urandom_range(99) < 15) begin
				repeat ($urandom_range(1, 3))
					chars.push_back(8'($urandom_range(1, 255)));
			end
		end
		send_text(chars, 1'b0, none);
	endtask

	// Receiver: random stalls, plus one long hold-off counted here.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_req) begin
				hold_req = 1'b0;
				hold_left = PRESSURE_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		parse_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_parses.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat %h", m_tdata));
			end else begin
				want = pending_parses.pop_front();
				if (m_tdata[VALUE_W-1:0] !== want.value)
					report_mismatch($sformatf("value %h, expected %h",
						m_tdata[VALUE_W-1:0], want.value));
				if (m_tdata[VALUE_W] !== want.parse_error)
					report_mismatch($sformatf("parse_error %b, expected %b",
						m_tdata[VALUE_W], want.parse_error));
			end
		end
	end

	initial begin : stimulus
		int send_idle_by_phase [4];
		int recv_stall_by_phase [4];
		logic [7:0] chars[$];
		parse_result_t row_res;
		send_idle_by_phase = '{0, 72, 0, 7};
		recv_stall_by_phase = '{0, 0, 72, 7};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		clear_parse();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			chars.delete();
			for (int i = 0; i < directed_rows[r].text.len(); i++)
				chars.push_back(directed_rows[r].text[i]);
			row_res.value = directed_rows[r].value;
			row_res.parse_error = directed_rows[r].err;
			send_text(chars, directed_rows[r].typed, row_res);
		end

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_idle_by_phase[p];
			recv_stall_pct = recv_stall_by_phase[p];
			bytes_sent = 0;
			while (bytes_sent < BYTES_PER_PHASE)
				send_random_string();
		end

		// Receiver holds off while short strings keep coming, so the result
		// register fills and the next terminator backs up the input.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b1;
		repeat (12) begin
			chars.delete();
			chars.push_back(sdip_pkg::CH_0 + 8'($urandom_range(9)));
			row_res = '0;
			send_text(chars, 1'b0, row_res);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_parses.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
